// ===== hdl/psc_pkg.sv =====
// package for preamble sync and phase correction
// constants, queue word type and the cordic arctangent table
package psc_pkg;

  localparam int SYNC_CHIPS         = 64;
  localparam int PREAMBLE_CHIPS_DEF = 128;
  localparam int PAYLOAD_CHIPS_DEF  = 64;
  localparam int CORDIC_STEPS_DEF   = 16;

  localparam logic [21:0] THR_RESET = 22'd19000;
  localparam logic [14:0] AMP_RESET = 15'd500;
  localparam logic [33:0] INV_GAIN_Q30 = 34'd652032874;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_AMPLITUDE = 2'd1;

  typedef struct packed {
    logic signed [15:0] chip_i;
    logic signed [15:0] chip_q;
    logic               sync;
    logic               last;
  } q_word_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/psc_chip_if.sv =====
// input channel: one received chip per word
// no dependencies
interface psc_chip_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] chip_i;
  logic signed [15:0] chip_q;
  modport source (output valid, chip_i, chip_q, input ready);
  modport sink (input valid, chip_i, chip_q, output ready);
endinterface

// ===== hdl/psc_res_if.sv =====
// output channel: one derotated payload chip per word
// no dependencies
interface psc_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_i;
  logic signed [15:0] out_q;
  logic               sync_ok;
  logic               frame_last;
  modport source (output valid, out_i, out_q, sync_ok, frame_last, input ready);
  modport sink (input valid, out_i, out_q, sync_ok, frame_last, output ready);
endinterface

// ===== hdl/psc_cordic.sv =====
// iterative cordic: correlation to angle, angle to q2.15 cos and sin
// depends on psc_pkg
module psc_cordic #(
  parameter int CORDIC_STEPS = psc_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [47:0] corr_re,
  input  logic signed [47:0] corr_im,
  output logic               done,
  output logic signed [16:0] phase_cos,
  output logic signed [16:0] phase_sin
);
  import psc_pkg::*;

  localparam int SW = $clog2(CORDIC_STEPS);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_VEC  = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_ROT  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]         state;
  logic [SW-1:0]      step;
  logic signed [51:0] vx, vy;
  logic [31:0]        ang;
  logic signed [33:0] rx, ry, rr;
  logic               flip;
  logic [31:0]        at;
  logic signed [33:0] at_s;
  logic signed [31:0] ang_s;
  logic               last_step;
  logic signed [33:0] fx, fy;
  logic signed [33:0] tx, ty;

  assign at = atan_entry(5'(step));
  assign at_s = $signed({2'b00, at});
  assign ang_s = $signed(ang);
  assign last_step = (step == SW'(CORDIC_STEPS - 1));
  assign fx = flip ? -rx : rx;
  assign fy = flip ? -ry : ry;
  assign tx = (fx + (fx[33] ? 34'sd16383 : 34'sd16384)) >>> 15;
  assign ty = (fy + (fy[33] ? 34'sd16383 : 34'sd16384)) >>> 15;

  function automatic logic signed [16:0] clamp17(input logic signed [33:0] v);
    logic signed [16:0] o;
    if (v > 34'sd32768) o = 17'sd32768;
    else if (v < -34'sd32768) o = -17'sd32768;
    else o = v[16:0];
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
      phase_cos <= 17'sd32768;
      phase_sin <= 17'sd0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            step <= '0;
            if (corr_re == 48'sd0 && corr_im == 48'sd0) begin
              ang <= 32'h0;
              state <= ST_PREP;
            end else begin
              state <= ST_VEC;
              if (corr_re < 0) begin
                vx <= -52'(corr_re);
                vy <= -52'(corr_im);
                ang <= 32'h80000000;
              end else begin
                vx <= 52'(corr_re);
                vy <= 52'(corr_im);
                ang <= 32'h0;
              end
            end
          end
        end
        ST_VEC: begin
          if (!vy[51]) begin
            vx <= vx + (vy >>> step);
            vy <= vy - (vx >>> step);
            ang <= ang + at;
          end else begin
            vx <= vx - (vy >>> step);
            vy <= vy + (vx >>> step);
            ang <= ang - at;
          end
          step <= step + 1'b1;
          if (last_step) state <= ST_PREP;
        end
        ST_PREP: begin
          rx <= INV_GAIN_Q30;
          ry <= '0;
          step <= '0;
          state <= ST_ROT;
          if (ang_s > 32'sh40000000) begin
            rr <= 34'(ang_s) - 34'sh80000000;
            flip <= 1'b1;
          end else if (ang_s < -32'sh40000000) begin
            rr <= 34'(ang_s) + 34'sh80000000;
            flip <= 1'b1;
          end else begin
            rr <= 34'(ang_s);
            flip <= 1'b0;
          end
        end
        ST_ROT: begin
          if (!rr[33]) begin
            rx <= rx - (ry >>> step);
            ry <= ry + (rx >>> step);
            rr <= rr - at_s;
          end else begin
            rx <= rx + (ry >>> step);
            ry <= ry - (rx >>> step);
            rr <= rr + at_s;
          end
          step <= step + 1'b1;
          if (last_step) state <= ST_FIN;
        end
        ST_FIN: begin
          phase_cos <= clamp17(tx);
          phase_sin <= clamp17(ty);
          done <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/psc_front.sv =====
// front part: takes chips, walsh sums, preamble correlation, sync decision,
// hands payload words to the queue and starts the cordic; depends on psc_pkg and psc_chip_if
module psc_front #(
  parameter int PREAMBLE_CHIPS = psc_pkg::PREAMBLE_CHIPS_DEF,
  parameter int PAYLOAD_CHIPS  = psc_pkg::PAYLOAD_CHIPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  psc_chip_if.sink           chip,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [21:0]        cfg_data,
  output psc_pkg::q_word_t   q_data,
  output logic               q_push,
  input  logic               q_ready,
  input  logic               back_idle,
  output logic               ph_start,
  output logic signed [47:0] corr_re,
  output logic signed [47:0] corr_im,
  input  logic               ph_done
);
  import psc_pkg::*;

  localparam int FRAME = PREAMBLE_CHIPS + PAYLOAD_CHIPS;
  localparam int CW = $clog2(FRAME);
  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_SQ    = 3'd1;
  localparam logic [2:0] ST_CMP   = 3'd2;
  localparam logic [2:0] ST_PWAIT = 3'd3;
  localparam logic [2:0] ST_PBUSY = 3'd4;

  logic [2:0]         state;
  logic [CW-1:0]      count;
  logic [21:0]        thr;
  logic [14:0]        amp;
  logic signed [23:0] acc_i, acc_q;
  logic               sync;
  logic               pend_phase;
  logic [43:0]        ai2, aq2, thr2;

  logic               is_pay, neg, accept, first;
  logic signed [16:0] sum_iq, dif_iq;
  logic signed [32:0] m_re, m_im;
  logic signed [23:0] base_i, base_q;
  logic signed [47:0] cbase_re, cbase_im;
  logic [23:0]        abs_i, abs_q;

  assign is_pay = (count >= CW'(PREAMBLE_CHIPS));
  assign neg = (count < CW'(SYNC_CHIPS)) && (^count[5:0]);
  assign first = (count == '0);
  assign chip.ready = (state == ST_RUN) && (!is_pay || q_ready);
  assign accept = chip.valid && chip.ready;
  assign sum_iq = 17'(chip.chip_i) + 17'(chip.chip_q);
  assign dif_iq = 17'(chip.chip_q) - 17'(chip.chip_i);
  assign m_re = $signed({1'b0, amp}) * sum_iq;
  assign m_im = $signed({1'b0, amp}) * dif_iq;
  assign base_i = first ? '0 : acc_i;
  assign base_q = first ? '0 : acc_q;
  assign cbase_re = first ? '0 : corr_re;
  assign cbase_im = first ? '0 : corr_im;
  assign abs_i = acc_i[23] ? 24'(-acc_i) : 24'(acc_i);
  assign abs_q = acc_q[23] ? 24'(-acc_q) : 24'(acc_q);

  assign q_push = accept && is_pay;
  assign q_data = '{chip_i: chip.chip_i, chip_q: chip.chip_q, sync: sync,
                    last: (count == CW'(FRAME - 1))};
  assign ph_start = (state == ST_PWAIT) && back_idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      count <= '0;
      thr <= THR_RESET;
      amp <= AMP_RESET;
      acc_i <= '0;
      acc_q <= '0;
      corr_re <= '0;
      corr_im <= '0;
      sync <= 1'b0;
      pend_phase <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_THRESHOLD) thr <= cfg_data;
      if (cfg_we && cfg_index == REG_AMPLITUDE) amp <= cfg_data[14:0];
      case (state)
        ST_RUN: begin
          if (accept) begin
            count <= (count == CW'(FRAME - 1)) ? '0 : count + 1'b1;
            if (!is_pay) begin
              if (count < CW'(SYNC_CHIPS)) begin
                acc_i <= neg ? base_i - 24'(chip.chip_i) : base_i + 24'(chip.chip_i);
                acc_q <= neg ? base_q - 24'(chip.chip_q) : base_q + 24'(chip.chip_q);
              end
              corr_re <= neg ? cbase_re - 48'(m_re) : cbase_re + 48'(m_re);
              corr_im <= neg ? cbase_im - 48'(m_im) : cbase_im + 48'(m_im);
              if (count == CW'(PREAMBLE_CHIPS - 1)) pend_phase <= 1'b1;
              if (count == CW'(SYNC_CHIPS - 1)) state <= ST_SQ;
              else if (count == CW'(PREAMBLE_CHIPS - 1)) state <= ST_PWAIT;
            end
          end
        end
        ST_SQ: begin
          ai2 <= abs_i[21:0] * abs_i[21:0];
          aq2 <= abs_q[21:0] * abs_q[21:0];
          thr2 <= thr * thr;
          state <= ST_CMP;
        end
        ST_CMP: begin
          sync <= ({1'b0, ai2} + {1'b0, aq2}) >= {1'b0, thr2};
          state <= pend_phase ? ST_PWAIT : ST_RUN;
        end
        ST_PWAIT: begin
          if (back_idle) state <= ST_PBUSY;
        end
        ST_PBUSY: begin
          if (ph_done) begin
            pend_phase <= 1'b0;
            state <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule

// ===== hdl/psc_back.sv =====
// back part: short word queue, derotation multiply, rounding and saturation,
// output register; depends on psc_pkg and psc_res_if
module psc_back (
  input  logic               clk,
  input  logic               rst,
  input  psc_pkg::q_word_t   q_data,
  input  logic               q_push,
  output logic               q_ready,
  output logic               idle,
  input  logic signed [16:0] phase_cos,
  input  logic signed [16:0] phase_sin,
  psc_res_if.source          res
);
  import psc_pkg::*;

  localparam int QD = 4;
  localparam int QW = $clog2(QD);

  q_word_t            mem [QD];
  logic [QW-1:0]      wp, rp;
  logic [QW:0]        fill;
  logic               s1_valid, s1_sync, s1_last;
  logic signed [32:0] p_ic, p_qs, p_qc, p_is;
  logic               adv, pop;
  logic signed [33:0] si, sq, ri, rq;
  q_word_t            head;

  assign head = mem[rp];
  assign adv = !res.valid || res.ready;
  assign pop = adv && (fill != '0);
  assign q_ready = (fill != (QW+1)'(QD));
  assign idle = (fill == '0) && !s1_valid;
  assign si = 34'(p_ic) + 34'(p_qs);
  assign sq = 34'(p_qc) - 34'(p_is);
  assign ri = (si + (si[33] ? 34'sd16383 : 34'sd16384)) >>> 15;
  assign rq = (sq + (sq[33] ? 34'sd16383 : 34'sd16384)) >>> 15;

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [15:0] o;
    if (v > 34'sd32767) o = 16'sh7FFF;
    else if (v < -34'sd32768) o = 16'sh8000;
    else o = v[15:0];
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (q_push) mem[wp] <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
      s1_valid <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (q_push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      fill <= fill + (QW+1)'(q_push) - (QW+1)'(pop);
      if (adv) begin
        s1_valid <= pop;
        res.valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p_ic <= head.chip_i * phase_cos;
      p_qs <= head.chip_q * phase_sin;
      p_qc <= head.chip_q * phase_cos;
      p_is <= head.chip_i * phase_sin;
      s1_sync <= head.sync;
      s1_last <= head.last;
    end
    if (adv && s1_valid) begin
      res.out_i <= s1_sync ? sat16(ri) : 16'sd0;
      res.out_q <= s1_sync ? sat16(rq) : 16'sd0;
      res.sync_ok <= s1_sync;
      res.frame_last <= s1_last;
    end
  end

endmodule

// ===== hdl/preamble_sync_phase_correct.sv =====
// top level: preamble sync and carrier phase correction
// depends on psc_pkg, psc_chip_if, psc_res_if, psc_front, psc_cordic, psc_back
//
// chip carries one received chip per word; frames are PREAMBLE_CHIPS preamble
// chips then PAYLOAD_CHIPS payload chips. preamble chips give no output word,
// each payload chip gives one word on res with the derotated chip (zero when
// sync failed), the sync flag of its frame and frame_last on the final chip.
// cfg_we writes register cfg_index (0 threshold, 1 amplitude) from cfg_data.
// chips are taken one per cycle, except that after the last sync chip the
// input pauses for the energy compare, and after the last preamble chip it
// pauses until earlier payload words have left the queue and then while
// the cordic runs one step per cycle. a payload word passes the queue, the
// product register and the output register on its way to res. a 4-word queue
// and the output register absorb a stall of res; once full, chip.ready drops
// on payload chips. reset clears counts, sums, sync flag and sets the phase
// to the identity rotation and registers to their defaults.
module preamble_sync_phase_correct #(
  parameter int PREAMBLE_CHIPS = psc_pkg::PREAMBLE_CHIPS_DEF,
  parameter int PAYLOAD_CHIPS  = psc_pkg::PAYLOAD_CHIPS_DEF,
  parameter int CORDIC_STEPS   = psc_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  psc_chip_if.sink    chip,
  psc_res_if.source   res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [21:0] cfg_data
);
  import psc_pkg::*;

  q_word_t            q_data;
  logic               q_push, q_ready, back_idle;
  logic               ph_start, ph_done;
  logic signed [47:0] corr_re, corr_im;
  logic signed [16:0] phase_cos, phase_sin;

  psc_front #(
    .PREAMBLE_CHIPS(PREAMBLE_CHIPS),
    .PAYLOAD_CHIPS (PAYLOAD_CHIPS)
  ) u_front (
    .clk, .rst, .chip, .cfg_we, .cfg_index, .cfg_data,
    .q_data, .q_push, .q_ready, .back_idle,
    .ph_start, .corr_re, .corr_im, .ph_done
  );

  psc_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk, .rst, .start(ph_start), .corr_re, .corr_im,
    .done(ph_done), .phase_cos, .phase_sin
  );

  psc_back u_back (
    .clk, .rst, .q_data, .q_push, .q_ready, .idle(back_idle),
    .phase_cos, .phase_sin, .res
  );

endmodule

// ===== tb/psc_tb_if.sv =====
// testbench-side note: channel interfaces come from the rtl (psc_chip_if, psc_res_if)
// this file holds the scoreboard word type shared by the testbench;
// it has no dependencies
`timescale 1ns / 1ps
package psc_tb_pkg;
  typedef struct packed {
    logic signed [15:0] out_i;
    logic signed [15:0] out_q;
    logic               sync_ok;
    logic               frame_last;
  } res_word_t;
endpackage

// ===== tb/tb.sv =====
// testbench for preamble_sync_phase_correct: frames of random and well-formed
// chips, a bit-exact phase predictor and a scoreboard for the payload words
// depends on psc_pkg, psc_tb_pkg, psc_chip_if, psc_res_if and the rtl
`timescale 1ns / 1ps
module tb;
  import psc_pkg::*;
  import psc_tb_pkg::*;

  localparam int PRE = 128;
  localparam int PAY = 64;
  localparam int FRAME = PRE + PAY;
  localparam int STEPS = 16;

  class derot_board;
    res_word_t pending[$];
    int errors;
    logic [21:0] thr;
    logic [14:0] amp;
    int unsigned pos;
    longint wi, wq, cr, ci;
    bit sync;
    longint pcos, psin;

    function void clear();
      pending.delete();
      errors = 0;
      thr = THR_RESET;
      amp = AMP_RESET;
      pos = 0;
      wi = 0; wq = 0; cr = 0; ci = 0;
      sync = 0;
      pcos = 32768;
      psin = 0;
    endfunction

    function longint rnd15(longint v);
      if (v >= 0) return (v + 16384) >>> 15;
      return -((-v + 16384) >>> 15);
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void update_phase();
      longint x, y, xn, r;
      logic [31:0] ang;
      bit flip;
      ang = 0;
      flip = 0;
      x = cr;
      y = ci;
      if (x != 0 || y != 0) begin
        if (x < 0) begin
          x = -x;
          y = -y;
          ang = 32'h80000000;
        end
        for (int k = 0; k < STEPS; k++) begin
          if (y >= 0) begin
            xn = x + (y >>> k);
            y = y - (x >>> k);
            ang = ang + atan_entry(5'(k));
          end else begin
            xn = x - (y >>> k);
            y = y + (x >>> k);
            ang = ang - atan_entry(5'(k));
          end
          x = xn;
        end
      end
      r = longint'(signed'(ang));
      if (r > 64'sh40000000) begin
        r -= 64'sh80000000;
        flip = 1;
      end else if (r < -64'sh40000000) begin
        r += 64'sh80000000;
        flip = 1;
      end
      x = 652032874;
      y = 0;
      for (int k = 0; k < STEPS; k++) begin
        if (r >= 0) begin
          xn = x - (y >>> k);
          y = y + (x >>> k);
          r -= longint'(atan_entry(5'(k)));
        end else begin
          xn = x + (y >>> k);
          y = y - (x >>> k);
          r += longint'(atan_entry(5'(k)));
        end
        x = xn;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      pcos = sat(rnd15(x), -32768, 32768);
      psin = sat(rnd15(y), -32768, 32768);
    endfunction

    function void note_chip(logic signed [15:0] di, logic signed [15:0] dq);
      longint a, b, v;
      res_word_t w;
      bit odd;
      a = di;
      b = dq;
      odd = ^pos[5:0];
      if (pos == 0) begin
        wi = 0; wq = 0; cr = 0; ci = 0;
      end
      if (pos < PRE) begin
        v = (pos < 64 && odd) ? -longint'(amp) : longint'(amp);
        if (pos < SYNC_CHIPS) begin
          if (odd) begin
            wi -= a; wq -= b;
          end else begin
            wi += a; wq += b;
          end
          if (pos == SYNC_CHIPS - 1)
            sync = (wi * wi + wq * wq) >= longint'(thr) * longint'(thr);
        end
        cr += v * (a + b);
        ci += v * (b - a);
        if (pos == PRE - 1) update_phase();
      end else begin
        w.out_i = sync ? 16'(sat(rnd15(a * pcos + b * psin), -32768, 32767)) : '0;
        w.out_q = sync ? 16'(sat(rnd15(b * pcos - a * psin), -32768, 32767)) : '0;
        w.sync_ok = sync;
        w.frame_last = (pos == FRAME - 1);
        pending.push_back(w);
      end
      pos = (pos + 1 >= FRAME) ? 0 : pos + 1;
    endfunction

    function void check_word(res_word_t got);
      res_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        $display("%0t: mismatch expected i=%0d q=%0d s=%0b l=%0b actual i=%0d q=%0d s=%0b l=%0b",
                 $time, exp_w.out_i, exp_w.out_q, exp_w.sync_ok, exp_w.frame_last,
                 got.out_i, got.out_q, got.sync_ok, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [21:0] cfg_data = '0;
  bit quiet = 0;
  bit done = 0;
  longint cycles = 0;

  psc_chip_if chip_ch();
  psc_res_if res_ch();
  derot_board board;

  preamble_sync_phase_correct dut (
    .clk(clk), .rst(rst), .chip(chip_ch.sink), .res(res_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    chip_ch.valid = 0;
    chip_ch.chip_i = '0;
    chip_ch.chip_q = '0;
    res_ch.ready = 0;
    board = new();
    board.clear();
  end

  // result side: check of every accepted word, and random stall bursts on ready
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready)
        board.check_word({res_ch.out_i, res_ch.out_q, res_ch.sync_ok, res_ch.frame_last});
    end
  end

  initial begin
    int n;
    @(posedge clk);
    forever begin
      res_ch.ready <= 1;
      n = $urandom_range(1, 30);
      repeat (n) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        res_ch.ready <= 0;
        n = $urandom_range(1, 14);
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000 && !done) begin
      $display("preamble_sync_phase_correct test failed");
      $finish;
    end
  end

  task automatic send_chip(logic signed [15:0] di, logic signed [15:0] dq);
    int n;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      chip_ch.valid <= 0;
      n = $urandom_range(1, 14);
      repeat (n) @(posedge clk);
    end
    chip_ch.valid <= 1;
    chip_ch.chip_i <= di;
    chip_ch.chip_q <= dq;
    @(posedge clk iff chip_ch.ready);
    board.note_chip(di, dq);
  endtask

  task automatic drain();
    chip_ch.valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (2 * STEPS + 12) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [21:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_THRESHOLD) board.thr = val;
    else if (idx == REG_AMPLITUDE) board.amp = val[14:0];
  endtask

  // mode 0 noise, 1 walsh pattern with random phase, 2 extremes, 3 zeros
  task automatic send_frame(int mode);
    logic signed [15:0] base_i, base_q, di, dq;
    int unsigned p;
    int unsigned sc;
    base_i = $urandom;
    base_q = $urandom;
    sc = $urandom_range(0, 3);
    for (int k = 0; k < FRAME; k++) begin
      p = k;
      di = $urandom;
      dq = $urandom;
      if (mode == 1 && k < PRE) begin
        di = base_i >>> sc;
        dq = base_q >>> sc;
        if (k < 64 && ^p[5:0]) begin
          di = -di;
          dq = -dq;
        end
        di = di + 16'($signed($urandom_range(0, 64)) - 32);
        dq = dq + 16'($signed($urandom_range(0, 64)) - 32);
      end else if (mode == 2) begin
        di = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
        dq = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
      end else if (mode == 3) begin
        di = 0;
        dq = 0;
      end
      send_chip(di, dq);
    end
  endtask

  initial begin
    int f;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_frame(3);
    send_frame(2);
    drain();
    write_reg(REG_THRESHOLD, 22'h3fffff);
    write_reg(REG_AMPLITUDE, 22'h7fff);
    send_frame(1);
    drain();
    write_reg(REG_THRESHOLD, 22'd0);
    write_reg(REG_AMPLITUDE, 22'd0);
    write_reg(2'd3, 22'h155555);
    send_frame(1);
    drain();
    write_reg(REG_AMPLITUDE, 22'h3fffff);
    send_frame(2);
    for (f = 0; f < 2; f++) begin
      drain();
      write_reg(REG_THRESHOLD, 22'($urandom_range(0, 200000)));
      write_reg(REG_AMPLITUDE, 22'($urandom_range(1, 32767)));
      send_frame($urandom_range(0, 3) == 0 ? 0 : 1);
    end
    quiet = 1;
    send_frame(1);
    drain();
    done = 1;
    if (board.errors == 0 && board.pending.size() == 0)
      $display("preamble_sync_phase_correct test passed");
    else
      $display("preamble_sync_phase_correct test failed");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/psc_pkg.sv
hdl/psc_chip_if.sv
hdl/psc_res_if.sv
hdl/psc_cordic.sv
hdl/psc_front.sv
hdl/psc_back.sv
hdl/preamble_sync_phase_correct.sv
tb/psc_tb_if.sv
tb/tb.sv
